### hw/rtl/content_length_deframer_top_macros.svh
// Assertion macros for the deframer checker
`ifndef CONTENT_LENGTH_DEFRAMER_TOP_MACROS_SVH
`define CONTENT_LENGTH_DEFRAMER_TOP_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define CLD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define CLD_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/cld_pkg.sv
// Shared types, constants and helpers for the content-length deframer
package cld_pkg;

  localparam int unsigned HdrCntW  = 17;
  localparam int unsigned HdrMaxW  = 16;
  localparam int unsigned MsgMaxW  = 24;
  localparam int unsigned LenW     = 25;
  localparam int unsigned PrefixLen = 15;
  localparam int unsigned PosW     = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;

  localparam logic [HdrMaxW-1:0] MaxHdrReset = 16'd4096;
  localparam logic [MsgMaxW-1:0] MaxMsgReset = 24'd1048576;
  localparam logic [LenW-1:0]    LenSat      = 25'h1000000;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_HEADER  = 1'b0,
    CFG_MAX_MESSAGE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FAILED   = 2'd1,
    ERR_HDR_LONG = 2'd2,
    ERR_BAD_LEN  = 2'd3
  } err_e;

  // End-mark tracker: nothing, CR, CRLF, CRLFCR
  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_CR     = 2'd1,
    MARK_CRLF   = 2'd2,
    MARK_CRLFCR = 2'd3
  } mark_e;

  // Per-line parser phase
  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_BLANK  = 2'd1,
    PH_DIGIT  = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       body_last;
    err_e       error_code;
  } result_t;

  // Characters of "Content-Length:"
  function automatic logic [7:0] prefix_char(input logic [PosW-1:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/content_length_deframer_top.sv
// A result is registered in the output buffer when its byte is accepted.
// One byte per cycle while in_stall_o is low; the per-byte parser update is one register stage.
// A two-entry result buffer lets one result wait while the next byte is taken.
// Reset (async, active low) clears parser state, drops buffered results and
// restores the limits to 4096 header bytes and 1048576 body bytes.
module content_length_deframer_top import cld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          byte_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                body_valid_o,
  output logic [7:0]          body_byte_o,
  output logic                body_last_o,
  output logic [1:0]          error_code_o
);

  logic [HdrMaxW-1:0] max_hdr_q;
  logic [MsgMaxW-1:0] max_msg_q;
  logic               buf_full;
  logic               accept;
  result_t            core_res, out_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !buf_full;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hdr_q <= MaxHdrReset;
      max_msg_q <= MaxMsgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_HEADER:  max_hdr_q <= cfg_data_i[HdrMaxW-1:0];
        CFG_MAX_MESSAGE: max_msg_q <= cfg_data_i[MsgMaxW-1:0];
        default: begin
        end
      endcase
    end
  end

  cld_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (byte_in_i),
    .max_hdr_i (max_hdr_q),
    .max_msg_i (max_msg_q),
    .result_o  (core_res)
  );

  cld_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (core_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign body_valid_o = out_res.body_valid;
  assign body_byte_o  = out_res.body_byte;
  assign body_last_o  = out_res.body_last;
  assign error_code_o = out_res.error_code;

endmodule

### hw/rtl/cld_core.sv
// Header parser and body counter: one state update per accepted byte
module cld_core import cld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  input  logic [HdrMaxW-1:0] max_hdr_i,
  input  logic [MsgMaxW-1:0] max_msg_i,
  output result_t            result_o
);

  logic                failed_q, failed_d;
  logic                in_body_q, in_body_d;
  logic [MsgMaxW-1:0]  remain_q, remain_d;
  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  mark_e               mark_q, mark_d;
  phase_e              phase_q, phase_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [LenW-1:0]     len_q, len_d;
  logic                seen_q, seen_d;
  logic                bad_q, bad_d;

  // Character classes
  logic       is_digit, is_blank;
  logic [3:0] digit_val;
  assign is_digit  = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_blank  = (byte_i == ChSpace) || (byte_i == ChTab);
  assign digit_val = 4'(byte_i - ChZero);

  // Decimal accumulate with saturation
  logic [LenW+2:0] len_x10;
  logic [LenW-1:0] len_acc;
  assign len_x10 = {len_q, 3'b000} + {2'b00, len_q, 1'b0} + (LenW+3)'(digit_val);
  assign len_acc = (len_x10 > (LenW+3)'(LenSat)) ? LenSat : len_x10[LenW-1:0];

  // One ordinary line character
  phase_e          lc_phase;
  logic [PosW-1:0] lc_pos;
  logic [LenW-1:0] lc_len;
  logic            lc_bad;
  always_comb begin
    lc_phase = phase_q;
    lc_pos   = pos_q;
    lc_len   = len_q;
    lc_bad   = bad_q;
    unique case (phase_q)
      PH_PREFIX: begin
        if ((pos_q < PosW'(PrefixLen)) && (byte_i == prefix_char(pos_q))) begin
          lc_pos = pos_q + PosW'(1);
          if (lc_pos >= PosW'(PrefixLen)) begin
            lc_phase = PH_BLANK;
          end
        end else begin
          lc_phase = PH_SKIP;
        end
      end
      PH_BLANK: begin
        if (is_digit) begin
          lc_len   = LenW'(digit_val);
          lc_phase = PH_DIGIT;
        end else if (!is_blank) begin
          lc_bad   = 1'b1;
          lc_phase = PH_SKIP;
        end
      end
      PH_DIGIT: begin
        if (is_digit) begin
          lc_len = len_acc;
        end else begin
          lc_bad   = 1'b1;
          lc_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
  end

  // A pending CR that turned out not to end the line: it spoils any length
  logic fl_bad;
  assign fl_bad = bad_q || (phase_q == PH_BLANK) || (phase_q == PH_DIGIT);

  // Step-level decisions
  logic               done;
  logic [HdrCntW-1:0] hdr_cnt_inc;
  logic               hdr_long;
  logic               len_bad;
  logic [MsgMaxW-1:0] remain_dec;
  assign done        = (mark_q == MARK_CRLFCR) && (byte_i == ChLf);
  assign hdr_cnt_inc = hdr_cnt_q + HdrCntW'(1);
  assign hdr_long    = !done && (hdr_cnt_inc > HdrCntW'(max_hdr_i));
  assign len_bad     = bad_q || !seen_q || (len_q == '0) || (len_q > LenW'(max_msg_i));
  assign remain_dec  = (remain_q == '0) ? '0 : remain_q - MsgMaxW'(1);

  // Next state
  logic clear_hdr;
  always_comb begin
    failed_d  = failed_q;
    in_body_d = in_body_q;
    remain_d  = remain_q;
    hdr_cnt_d = hdr_cnt_q;
    mark_d    = mark_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_d     = len_q;
    seen_d    = seen_q;
    bad_d     = bad_q;
    clear_hdr = 1'b0;
    if (accept_i && !failed_q) begin
      if (in_body_q) begin
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          in_body_d = 1'b0;
          clear_hdr = 1'b1;
        end
      end else begin
        hdr_cnt_d = hdr_cnt_inc;
        unique case (mark_q)
          MARK_NONE: begin
            if (byte_i == ChCr) begin
              mark_d = MARK_CR;
            end else begin
              phase_d = lc_phase;
              pos_d   = lc_pos;
              len_d   = lc_len;
              bad_d   = lc_bad;
            end
          end
          MARK_CR: begin
            if (byte_i == ChLf) begin
              // Line end
              bad_d   = bad_q || (phase_q == PH_BLANK) ||
                        ((phase_q == PH_DIGIT) && seen_q);
              seen_d  = seen_q || (phase_q == PH_DIGIT);
              phase_d = PH_PREFIX;
              pos_d   = '0;
              mark_d  = MARK_CRLF;
            end else begin
              phase_d = PH_SKIP;
              bad_d   = fl_bad;
              mark_d  = (byte_i == ChCr) ? MARK_CR : MARK_NONE;
            end
          end
          MARK_CRLF: begin
            if (byte_i == ChCr) begin
              mark_d = MARK_CRLFCR;
            end else begin
              phase_d = lc_phase;
              pos_d   = lc_pos;
              len_d   = lc_len;
              bad_d   = lc_bad;
              mark_d  = MARK_NONE;
            end
          end
          MARK_CRLFCR: begin
            if (!done) begin
              phase_d = PH_SKIP;
              bad_d   = fl_bad;
              mark_d  = (byte_i == ChCr) ? MARK_CR : MARK_NONE;
            end
          end
          default: begin
          end
        endcase
        if (done) begin
          clear_hdr = 1'b1;
          if (len_bad) begin
            failed_d = 1'b1;
            remain_d = '0;
          end else begin
            in_body_d = 1'b1;
            remain_d  = len_q[MsgMaxW-1:0];
          end
        end else if (hdr_long) begin
          clear_hdr = 1'b1;
          failed_d  = 1'b1;
          in_body_d = 1'b0;
          remain_d  = '0;
        end
      end
    end
    if (clear_hdr) begin
      hdr_cnt_d = '0;
      mark_d    = MARK_NONE;
      phase_d   = PH_PREFIX;
      pos_d     = '0;
      len_d     = '0;
      seen_d    = 1'b0;
      bad_d     = 1'b0;
    end
  end

  // Result for the byte being accepted
  always_comb begin
    result_o = '{body_valid: 1'b0, body_byte: 8'h00, body_last: 1'b0,
                 error_code: ERR_NONE};
    if (failed_q) begin
      result_o.error_code = ERR_FAILED;
    end else if (in_body_q) begin
      result_o.body_valid = 1'b1;
      result_o.body_byte  = byte_i;
      result_o.body_last  = (remain_dec == '0);
    end else if (done) begin
      if (len_bad) begin
        result_o.error_code = ERR_BAD_LEN;
      end
    end else if (hdr_long) begin
      result_o.error_code = ERR_HDR_LONG;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q  <= 1'b0;
      in_body_q <= 1'b0;
      remain_q  <= '0;
      hdr_cnt_q <= '0;
      mark_q    <= MARK_NONE;
      phase_q   <= PH_PREFIX;
      pos_q     <= '0;
      len_q     <= '0;
      seen_q    <= 1'b0;
      bad_q     <= 1'b0;
    end else begin
      failed_q  <= failed_d;
      in_body_q <= in_body_d;
      remain_q  <= remain_d;
      hdr_cnt_q <= hdr_cnt_d;
      mark_q    <= mark_d;
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      seen_q    <= seen_d;
      bad_q     <= bad_d;
    end
  end

endmodule

### hw/rtl/cld_out_buf.sv
// Result register with a skid stage so input and output stall independently
module cld_out_buf import cld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_v_q, skid_v_q;
  result_t main_q, skid_q;
  logic    pop, main_free;

  assign pop       = main_v_q && !out_stall_i;
  assign main_free = !main_v_q || pop;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (main_free) begin
      main_v_q <= skid_v_q || push_i;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_v_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

endmodule

### hw/rtl/cld_checker.sv
// Port-level checker for the deframer, bound to the top level
`include "content_length_deframer_top_macros.svh"

module cld_checker import cld_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                body_valid_o,
  input logic [7:0]          body_byte_o,
  input logic                body_last_o,
  input logic [1:0]          error_code_o
);

  // Set once any error transaction has left the block
  logic fail_seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && (error_code_o != ERR_NONE)) begin
      fail_seen_q <= 1'b1;
    end
  end

  `CLD_ASSERT(a_err_no_body,
    out_valid_o && (error_code_o != ERR_NONE) |->
      !body_valid_o && (body_byte_o == 8'h00) && !body_last_o,
    "error transaction carries body data")

  `CLD_ASSERT(a_last_is_body,
    out_valid_o && body_last_o |-> body_valid_o && (error_code_o == ERR_NONE),
    "last flag without a body byte")

  `CLD_ASSERT(a_fail_sticky,
    out_valid_o && fail_seen_q |-> (error_code_o == ERR_FAILED) && !body_valid_o,
    "block recovered from a failure without reset")

  `CLD_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(body_valid_o) && $stable(body_byte_o) &&
      $stable(body_last_o) && $stable(error_code_o),
    "stalled result changed")

  `CLD_ASSERT_RST(a_reset_idle,
    !rst_ni |-> !out_valid_o && !in_stall_o,
    "outputs active during reset")

endmodule

bind content_length_deframer_top cld_checker u_cld_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the content-length deframer: byte stream driver and scoreboard
import cld_pkg::*;

// Byte-level predictor of the deframer plus the queue of results it still owes
class deframe_sb;
  logic [15:0] max_hdr;
  logic [23:0] max_msg;
  bit          failed;
  bit          in_body;
  logic [23:0] body_left;
  logic [16:0] hdr_count;
  mark_e       mark;
  phase_e      phase;
  logic [3:0]  key_pos;
  logic [24:0] len_val;
  bit          len_seen;
  bit          hdr_bad;
  result_t     owed_beats[$];
  int          errors;

  function new();
    max_hdr   = MaxHdrReset;
    max_msg   = MaxMsgReset;
    failed    = 1'b0;
    in_body   = 1'b0;
    body_left = '0;
    errors    = 0;
    clear_header();
  endfunction

  function void clear_header();
    hdr_count = '0;
    mark      = MARK_NONE;
    phase     = PH_PREFIX;
    key_pos   = '0;
    len_val   = '0;
    len_seen  = 1'b0;
    hdr_bad   = 1'b0;
  endfunction

  function void write_reg(cfg_idx_e idx, logic [23:0] data);
    if (idx == CFG_MAX_HEADER) begin
      max_hdr = data[15:0];
    end else begin
      max_msg = data;
    end
  endfunction

  // One character of a header line, CRLF already stripped
  function void line_char(logic [7:0] c);
    string       key;
    bit          digit;
    logic [31:0] acc;
    key   = "Content-Length:";
    digit = (c >= ChZero) && (c <= ChNine);
    case (phase)
      PH_PREFIX: begin
        if (key_pos < PrefixLen && c == key[key_pos]) begin
          key_pos++;
          if (key_pos >= PrefixLen) phase = PH_BLANK;
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_BLANK: begin
        if (!(c == ChSpace || c == ChTab)) begin
          if (digit) begin
            len_val = 25'(c - ChZero);
            phase   = PH_DIGIT;
          end else begin
            hdr_bad = 1'b1;
            phase   = PH_SKIP;
          end
        end
      end
      PH_DIGIT: begin
        if (digit) begin
          acc     = 32'(len_val) * 32'd10 + 32'(c - ChZero);
          len_val = (acc > 32'(LenSat)) ? LenSat : acc[24:0];
        end else begin
          hdr_bad = 1'b1;
          phase   = PH_SKIP;
        end
      end
      default: ;
    endcase
  endfunction

  function void close_line();
    if (phase == PH_BLANK) begin
      hdr_bad = 1'b1;
    end else if (phase == PH_DIGIT) begin
      if (len_seen) hdr_bad = 1'b1;
      len_seen = 1'b1;
    end
    phase   = PH_PREFIX;
    key_pos = '0;
  endfunction

  function void fail_all();
    failed    = 1'b1;
    in_body   = 1'b0;
    body_left = '0;
    clear_header();
  endfunction

  // Accepted input byte: advance the parser and queue the result it causes
  function void note_byte(logic [7:0] c);
    result_t r;
    bit      done;
    r            = '0;
    r.error_code = ERR_NONE;
    done         = 1'b0;
    if (failed) begin
      r.error_code = ERR_FAILED;
    end else if (in_body) begin
      r.body_valid = 1'b1;
      r.body_byte  = c;
      if (body_left != 0) body_left--;
      if (body_left == 0) begin
        r.body_last = 1'b1;
        in_body     = 1'b0;
        clear_header();
      end
    end else begin
      hdr_count = hdr_count + 17'd1;
      case (mark)
        MARK_NONE: begin
          if (c == ChCr) mark = MARK_CR;
          else line_char(c);
        end
        MARK_CR: begin
          if (c == ChLf) begin
            close_line();
            mark = MARK_CRLF;
          end else if (c == ChCr) begin
            line_char(ChCr);
          end else begin
            line_char(ChCr);
            line_char(c);
            mark = MARK_NONE;
          end
        end
        MARK_CRLF: begin
          if (c == ChCr) begin
            mark = MARK_CRLFCR;
          end else begin
            line_char(c);
            mark = MARK_NONE;
          end
        end
        default: begin
          if (c == ChLf) begin
            done = 1'b1;
          end else if (c == ChCr) begin
            line_char(ChCr);
            mark = MARK_CR;
          end else begin
            line_char(ChCr);
            line_char(c);
            mark = MARK_NONE;
          end
        end
      endcase
      if (!done) begin
        if (hdr_count > {1'b0, max_hdr}) begin
          fail_all();
          r.error_code = ERR_HDR_LONG;
        end
      end else if (hdr_bad || !len_seen || len_val == 0 || len_val > {1'b0, max_msg}) begin
        fail_all();
        r.error_code = ERR_BAD_LEN;
      end else begin
        body_left = len_val[23:0];
        in_body   = 1'b1;
        clear_header();
      end
    end
    owed_beats = {owed_beats, r};
  endfunction

  // Compare one delivered result with the oldest prediction
  function void check_result(result_t got);
    result_t want;
    if (owed_beats.size() == 0) begin
      $error("unexpected result: no accepted byte outstanding");
      errors++;
      return;
    end
    want = owed_beats.pop_front();
    if (got.body_valid !== want.body_valid) begin
      $error("body_valid: expected %0d, actual %0d", want.body_valid, got.body_valid);
      errors++;
    end
    if (got.body_byte !== want.body_byte) begin
      $error("body_byte: expected 0x%02h, actual 0x%02h", want.body_byte, got.body_byte);
      errors++;
    end
    if (got.body_last !== want.body_last) begin
      $error("body_last: expected %0d, actual %0d", want.body_last, got.body_last);
      errors++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
      errors++;
    end
  endfunction

  function int pending();
    return owed_beats.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cld_pkg::*;

  // Ways to break the stream at the end of the run (errors are sticky)
  typedef enum int {
    FAULT_NO_LEN,
    FAULT_NO_DIGITS,
    FAULT_TRAILING,
    FAULT_TWICE,
    FAULT_ZERO,
    FAULT_OVER,
    FAULT_SATURATE,
    FAULT_HDR_LONG
  } fault_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          byte_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                body_valid_o;
  logic [7:0]          body_byte_o;
  logic                body_last_o;
  logic [1:0]          error_code_o;

  deframe_sb   sb;
  logic [7:0]  msg_bytes[$];
  int unsigned bytes_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_cycles;

  content_length_deframer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .body_valid_o (body_valid_o),
    .body_byte_o  (body_byte_o),
    .body_last_o  (body_last_o),
    .error_code_o (error_code_o)
  );

  always #6 clk_i = ~clk_i;

  // Run limit, far above the slowest legal run
  initial begin
    #6ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall, or a long hold-off when one is requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        recv_hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Monitor both channels; input is noted before the result is checked
  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(byte_in_i);
      if (out_valid_o && !out_stall_i) begin
        seen.body_valid = body_valid_o;
        seen.body_byte  = body_byte_o;
        seen.body_last  = body_last_o;
        seen.error_code = err_e'(error_code_o);
        sb.check_result(seen);
      end
    end
  end

  // One byte transaction, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i]);
    msg_bytes.delete();
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write both limit registers; only called while the block is idle
  task automatic set_limits(logic [23:0] hdr_data, logic [23:0] msg_data);
    cfg_idx_e    idx;
    logic [23:0] data;
    for (int k = 0; k < 2; k++) begin
      idx  = (k == 0) ? CFG_MAX_HEADER : CFG_MAX_MESSAGE;
      data = (k == 0) ? hdr_data : msg_data;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(idx, data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Append one byte to the frame being built
  function automatic void add_byte(logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(ChCr);
    add_byte(ChLf);
  endfunction

  // Arbitrary bytes that never form a CRLF pair
  function automatic void add_junk(int unsigned n, logic [7:0] prev);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom);
      if (prev == ChCr && c == ChLf) c = 8'h2E;
      add_byte(c);
      prev = c;
    end
  endfunction

  // Length line with optional blanks and leading zeros
  function automatic void add_length_line(int unsigned n);
    add_text("Content-Length:");
    repeat ($urandom_range(0, 3)) add_byte($urandom_range(0, 1) ? ChSpace : ChTab);
    repeat ($urandom_range(0, 3)) add_byte(ChZero);
    add_text($sformatf("%0d", n));
    add_crlf();
  endfunction

  // Header line the parser must ignore
  function automatic void add_filler_line();
    string       key;
    int unsigned cut;
    logic [7:0]  c;
    key = "Content-Length:";
    case ($urandom_range(0, 3))
      0: add_junk($urandom_range(1, 16), 8'h00);
      1: begin
        // start of the key, then a character that breaks it
        cut = $urandom_range(0, 14);
        for (int i = 0; i < cut; i++) add_byte(key[i]);
        c = 8'($urandom);
        if (c == key[cut] || c == ChCr) c = 8'h3F;
        add_byte(c);
        add_junk($urandom_range(0, 6), c);
      end
      2: add_text($sformatf("content-length: %0d", $urandom_range(0, 99999)));
      default: add_text($sformatf("X-Seq: %0h", $urandom));
    endcase
    add_crlf();
  endfunction

  // Well-formed message: filler lines around one length line, then the body
  task automatic send_message(int unsigned body_len);
    int unsigned fillers;
    int unsigned at;
    fillers = $urandom_range(0, 3);
    at      = $urandom_range(0, fillers);
    for (int i = 0; i <= fillers; i++) begin
      if (i == at) add_length_line(body_len);
      else add_filler_line();
    end
    add_crlf();
    repeat (body_len) add_byte(8'($urandom));
    send_frame();
  endtask

  // Mostly short bodies, now and then a longer one
  function automatic int unsigned pick_body_len();
    int unsigned top;
    top = (sb.max_msg < 40) ? sb.max_msg : 40;
    if ($urandom_range(0, 29) == 0) top = (sb.max_msg < 400) ? sb.max_msg : 400;
    return $urandom_range(1, top);
  endfunction

  // Final broken message; the block stays failed afterwards
  task automatic break_stream();
    fault_e      fault;
    int unsigned lim;
    fault = fault_e'($urandom_range(0, 7));
    case (fault)
      FAULT_NO_LEN: begin
        add_filler_line();
        add_filler_line();
      end
      FAULT_NO_DIGITS: begin
        add_text("Content-Length: \t");
        add_crlf();
      end
      FAULT_TRAILING: begin
        // stray character or lone CR after the digits
        add_text("Content-Length: 12");
        add_byte($urandom_range(0, 1) ? ChCr : 8'h78);
        add_crlf();
      end
      FAULT_TWICE: begin
        add_length_line(5);
        add_filler_line();
        add_length_line(5);
      end
      FAULT_ZERO: begin
        add_text("Content-Length: 000");
        add_crlf();
      end
      FAULT_OVER: begin
        lim = $urandom_range(1, 1000);
        set_limits(24'd4096, 24'(lim));
        add_length_line(lim + 1);
      end
      FAULT_SATURATE: begin
        add_text("Content-Length: 99999999999");
        add_crlf();
      end
      default: begin
        set_limits(24'($urandom_range(4, 16)), sb.max_msg);
        add_length_line(3);
      end
    endcase
    add_crlf();
    repeat (6) add_byte(8'($urandom));
    send_frame();
    settle();
  endtask

  initial begin
    int unsigned seg;
    int unsigned next_cfg;
    bit          held;
    logic [23:0] hdr_data;
    logic [23:0] msg_data;

    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_MAX_HEADER;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    byte_in_i        = '0;
    bytes_sent       = 0;
    send_idle_pct    = 15;
    recv_idle_pct    = 58;
    recv_hold_cycles = 0;
    sb               = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: ignored lines, lone CR and LF, blanks and leading zeros
    add_text("content-length: 9");
    add_crlf();
    add_byte(8'h58);
    add_byte(ChCr);
    add_byte(8'h59);
    add_byte(ChLf);
    add_byte(8'h5A);
    add_crlf();
    add_text("Content-Lengt: 4");
    add_crlf();
    add_text("Content-Length:\t 007");
    add_crlf();
    add_crlf();
    add_crlf();
    add_crlf();
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'h80);
    send_frame();
    settle();

    // Header exactly at its limit, smallest body limit
    set_limits(24'd19, 24'd1);
    add_text("Content-Length:1");
    add_crlf();
    add_crlf();
    add_byte(8'hA5);
    send_frame();
    settle();

    // Largest limits; header data carries set upper bits
    set_limits(24'hFFFFFF, 24'hFFFFFF);
    add_text("Content-Length: 00000000003");
    add_crlf();
    add_crlf();
    repeat (3) add_byte(8'($urandom));
    send_frame();

    // Random well-formed traffic under changing limits and idle profiles
    seg      = 0;
    next_cfg = 0;
    held     = 1'b0;
    while (bytes_sent < 1500) begin
      if (bytes_sent < 517) begin
        send_idle_pct = 15;
        recv_idle_pct = 58;
      end else if (bytes_sent < 1034) begin
        send_idle_pct = 58;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (bytes_sent >= next_cfg) begin
        settle();
        case (seg % 4)
          0: begin
            hdr_data = {8'($urandom), 16'($urandom_range(128, 65535))};
            msg_data = 24'($urandom_range(64, 24'hFFFFFF));
          end
          1: begin
            hdr_data = 24'h00FFFF;
            msg_data = 24'hFFFFFF;
          end
          2: begin
            hdr_data = {8'($urandom), 16'($urandom_range(128, 4096))};
            msg_data = 24'd1;
          end
          default: begin
            hdr_data = {8'($urandom), 16'($urandom_range(128, 65535))};
            msg_data = 24'($urandom_range(1, 63));
          end
        endcase
        set_limits(hdr_data, msg_data);
        seg++;
        next_cfg = bytes_sent + 260;
      end
      // long receiver hold-off so the block backs up into its input
      if (!held && bytes_sent >= 300) begin
        recv_hold_cycles = 64;
        held             = 1'b1;
      end
      send_message(pick_body_len());
    end
    settle();

    // Break the stream, then confirm the failure sticks under new limits
    break_stream();
    set_limits({8'hFF, 16'd4}, 24'($urandom));
    repeat (10) add_byte(8'($urandom));
    send_frame();
    settle();

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
